// ----- design/bmhq_pkg.sv -----
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared constants, codes and types of the binary max-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

	localparam int DEPTH = 1024;
	localparam int KEY_W = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int STAT_W = 2;

	// request kinds
	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_POP    = 1'b1
	} req_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} stat_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP_CHK,
		ST_UP_CMP,
		ST_DN_LAST,
		ST_DN_CHK,
		ST_DN_RDR,
		ST_DN_SEL,
		ST_DN_CMP,
		ST_DONE
	} state_t;

	typedef logic signed [KEY_W-1:0] key_t;

	typedef struct packed {
		key_t             removed_key;
		key_t             top_key;
		logic             top_valid;
		logic [CNT_W-1:0] entry_count;
		stat_t            status;
	} result_t;

endpackage

`default_nettype wire

// ----- design/bmhq_core.sv -----
// ----------------------------------------------------------------------------
// bmhq_core
// Heap store, entry count and the sift sequencer around one key comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_core (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire bmhq_pkg::req_t     req_type,
	input  wire bmhq_pkg::key_t     key,
	output logic                    idle,
	output logic                    done,
	output bmhq_pkg::result_t       result
);

	localparam int IDX_W = bmhq_pkg::IDX_W;
	localparam int CNT_W = bmhq_pkg::CNT_W;
	localparam int CHL_W = IDX_W + 2;

	bmhq_pkg::key_t heap_mem [bmhq_pkg::DEPTH];
	bmhq_pkg::key_t rd_data_q;
	bmhq_pkg::key_t root_q;

	bmhq_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] fill_q, fill_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [IDX_W-1:0] cidx_q, cidx_d;
	bmhq_pkg::key_t   cur_q, cur_d;
	bmhq_pkg::key_t   child_q, child_d;
	bmhq_pkg::key_t   removed_q, removed_d;
	bmhq_pkg::stat_t  status_q, status_d;

	logic             we;
	logic [IDX_W-1:0] waddr;
	bmhq_pkg::key_t   wdata;
	logic             re;
	logic [IDX_W-1:0] raddr;

	bmhq_pkg::key_t   cmp_a, cmp_b;
	logic             cmp_lt;

	logic [CHL_W-1:0] lchild, rchild, fill_ext;
	logic [IDX_W-1:0] parent;

	assign lchild   = {1'b0, idx_q, 1'b1};
	assign rchild   = lchild + CHL_W'(1);
	assign fill_ext = CHL_W'(fill_q);
	assign parent   = (idx_q - IDX_W'(1)) >> 1;

	// the one shared comparator
	assign cmp_lt = cmp_a < cmp_b;

	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		idx_d     = idx_q;
		cidx_d    = cidx_q;
		cur_d     = cur_q;
		child_d   = child_q;
		removed_d = removed_q;
		status_d  = status_q;
		we        = 1'b0;
		waddr     = idx_q;
		wdata     = cur_q;
		re        = 1'b0;
		raddr     = idx_q;
		cmp_a     = rd_data_q;
		cmp_b     = cur_q;
		idle      = 1'b0;
		done      = 1'b0;
		unique case (state_q)
			bmhq_pkg::ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					removed_d = '0;
					status_d  = bmhq_pkg::STAT_DONE;
					if (req_type == bmhq_pkg::REQ_INSERT) begin
						if (fill_q == CNT_W'(bmhq_pkg::DEPTH)) begin
							status_d = bmhq_pkg::STAT_FULL;
							state_d  = bmhq_pkg::ST_DONE;
						end else begin
							cur_d   = key;
							idx_d   = fill_q[IDX_W-1:0];
							fill_d  = fill_q + CNT_W'(1);
							state_d = bmhq_pkg::ST_UP_CHK;
						end
					end else begin
						if (fill_q == '0) begin
							status_d = bmhq_pkg::STAT_EMPTY;
							state_d  = bmhq_pkg::ST_DONE;
						end else begin
							removed_d = root_q;
							fill_d    = fill_q - CNT_W'(1);
							if (fill_q == CNT_W'(1)) begin
								state_d = bmhq_pkg::ST_DONE;
							end else begin
								// fetch the last entry, it becomes the new root
								re      = 1'b1;
								raddr   = IDX_W'(fill_q - CNT_W'(1));
								state_d = bmhq_pkg::ST_DN_LAST;
							end
						end
					end
				end
			end
			bmhq_pkg::ST_UP_CHK: begin
				if (idx_q == '0) begin
					we      = 1'b1;
					state_d = bmhq_pkg::ST_DONE;
				end else begin
					re      = 1'b1;
					raddr   = parent;
					state_d = bmhq_pkg::ST_UP_CMP;
				end
			end
			bmhq_pkg::ST_UP_CMP: begin
				cmp_a = rd_data_q;
				cmp_b = cur_q;
				we    = 1'b1;
				if (cmp_lt) begin
					// parent moves down into the hole
					wdata   = rd_data_q;
					idx_d   = parent;
					state_d = bmhq_pkg::ST_UP_CHK;
				end else begin
					state_d = bmhq_pkg::ST_DONE;
				end
			end
			bmhq_pkg::ST_DN_LAST: begin
				cur_d   = rd_data_q;
				idx_d   = '0;
				state_d = bmhq_pkg::ST_DN_CHK;
			end
			bmhq_pkg::ST_DN_CHK: begin
				if (lchild >= fill_ext) begin
					we      = 1'b1;
					state_d = bmhq_pkg::ST_DONE;
				end else begin
					re      = 1'b1;
					raddr   = lchild[IDX_W-1:0];
					state_d = bmhq_pkg::ST_DN_RDR;
				end
			end
			bmhq_pkg::ST_DN_RDR: begin
				child_d = rd_data_q;
				cidx_d  = lchild[IDX_W-1:0];
				if (rchild < fill_ext) begin
					re      = 1'b1;
					raddr   = rchild[IDX_W-1:0];
					state_d = bmhq_pkg::ST_DN_SEL;
				end else begin
					state_d = bmhq_pkg::ST_DN_CMP;
				end
			end
			bmhq_pkg::ST_DN_SEL: begin
				// right child wins ties
				cmp_a = rd_data_q;
				cmp_b = child_q;
				if (!cmp_lt) begin
					child_d = rd_data_q;
					cidx_d  = rchild[IDX_W-1:0];
				end
				state_d = bmhq_pkg::ST_DN_CMP;
			end
			bmhq_pkg::ST_DN_CMP: begin
				cmp_a = cur_q;
				cmp_b = child_q;
				we    = 1'b1;
				if (cmp_lt) begin
					wdata   = child_q;
					idx_d   = cidx_q;
					state_d = bmhq_pkg::ST_DN_CHK;
				end else begin
					state_d = bmhq_pkg::ST_DONE;
				end
			end
			bmhq_pkg::ST_DONE: begin
				done    = 1'b1;
				state_d = bmhq_pkg::ST_IDLE;
			end
			default: begin
				state_d = bmhq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmhq_pkg::ST_IDLE;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q     <= idx_d;
		cidx_q    <= cidx_d;
		cur_q     <= cur_d;
		child_q   <= child_d;
		removed_q <= removed_d;
		status_q  <= status_d;
		// copy of entry zero so the maximum is always at hand
		if (we && waddr == '0) begin
			root_q <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			heap_mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= heap_mem[raddr];
		end
	end

	always_comb begin
		result.removed_key = removed_q;
		result.top_valid   = (fill_q != '0);
		result.top_key     = (fill_q != '0) ? root_q : '0;
		result.entry_count = fill_q;
		result.status      = status_q;
	end

endmodule

`default_nettype wire

// ----- design/binary_max_heap_queue_top.sv -----
// ----------------------------------------------------------------------------
// binary_max_heap_queue_top
// Max-heap priority queue of signed keys with stream input and output.
// ----------------------------------------------------------------------------
//  channel   | dir | item contents
//  ----------+-----+---------------------------------------------------------
//  s_*       | in  | tuser: req_type; tdata: key
//  m_*       | out | tdata: removed_key, top_key, top_valid, entry_count, status
//
//  an insert places the key at the end and climbs, reading and comparing the parent per level
//  a pop moves the last entry to the root and sifts it down, reading one or both children per level
//  a pop on empty, a pop of the only entry and an insert when full go straight to the result
//  the single-port heap memory read and the one key comparator set the pace
//  s_tready is low while an item is in work and while a result waits on m_*
//  reset empties the heap at once, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module binary_max_heap_queue_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // key
	input  wire  [0:0]  s_tuser,   // req_type
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [79:0] m_tdata    // removed_key, top_key, top_valid, entry_count, status
);

	logic              core_idle;
	logic              core_done;
	logic              start;
	bmhq_pkg::result_t core_res;
	logic              m_tvalid_q;
	logic [79:0]       m_tdata_q;

	assign s_tready = core_idle && !m_tvalid_q;
	assign start    = s_tvalid && s_tready;

	bmhq_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (bmhq_pkg::req_t'(s_tuser[0])),
		.key      (bmhq_pkg::key_t'(s_tdata)),
		.idle     (core_idle),
		.done     (core_done),
		.result   (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (core_done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_done) begin
			m_tdata_q <= {2'b00, core_res.status, core_res.entry_count, core_res.top_valid,
				core_res.top_key, core_res.removed_key};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire
